// File: sv/sks1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sks1_pkg;

    // Key table geometry that does not vary
    localparam int TABLE_ROWS = 128;
    localparam int ROW_BITS   = 7;

    // Word kinds carried on the input tuser
    localparam logic OP_SCAN        = 1'b0;
    localparam logic OP_TABLE_WRITE = 1'b1;

    // Prefix decoder phases
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_E0         = 4'd1;
    localparam logic [3:0] PH_PS_MAKE_E0 = 4'd2;
    localparam logic [3:0] PH_PS_MAKE_37 = 4'd3;
    localparam logic [3:0] PH_PS_BRK_E0  = 4'd4;
    localparam logic [3:0] PH_PS_BRK_AA  = 4'd5;
    localparam logic [3:0] PH_PAUSE      = 4'd6;

    // Modifier flag positions
    localparam int MOD_SHIFT_L = 0;
    localparam int MOD_SHIFT_R = 1;
    localparam int MOD_CTRL_L  = 2;
    localparam int MOD_CTRL_R  = 3;
    localparam int MOD_ALT_L   = 4;
    localparam int MOD_ALT_R   = 5;

    // Scan code set 1 bytes
    localparam logic [7:0] SC_PREFIX_E0  = 8'hE0;
    localparam logic [7:0] SC_PREFIX_E1  = 8'hE1;
    localparam logic [7:0] SC_PS_MAKE    = 8'h2A;
    localparam logic [7:0] SC_PS_BREAK   = 8'hB7;
    localparam logic [7:0] SC_PS_KEY     = 8'h37;
    localparam logic [7:0] SC_PS_RELEASE = 8'hAA;
    localparam logic [7:0] SC_CTRL_MAKE  = 8'h1D;
    localparam logic [7:0] SC_CTRL_BREAK = 8'h9D;
    localparam logic [7:0] SC_ALT_MAKE   = 8'h38;
    localparam logic [7:0] SC_ALT_BREAK  = 8'hB8;

    // Plain rows (low seven bits of the byte)
    localparam logic [6:0] ROW_ESCAPE  = 7'h01;
    localparam logic [6:0] ROW_CTRL_L  = 7'h1D;
    localparam logic [6:0] ROW_SHIFT_L = 7'h2A;
    localparam logic [6:0] ROW_SHIFT_R = 7'h36;
    localparam logic [6:0] ROW_ALT_L   = 7'h38;

    // Pause sequence: E1 1D 45 E1 9D C5
    localparam logic [2:0] PAUSE_LEN = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] REG_PAUSE_CODE    = 2'd0;
    localparam logic [1:0] REG_PRINT_SCREEN  = 2'd1;
    localparam logic [1:0] REG_OTHER_PREFIX  = 2'd2;

    typedef struct packed {
        logic [3:0] phase;
        logic [2:0] pause_cnt;
        logic [5:0] mods;
    } dec_state_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] key_code;
        logic        is_make;
        logic        shift_held;
        logic        ctrl_held;
        logic        alt_held;
    } key_result_t;

    function automatic logic [7:0] pause_byte(input logic [2:0] pos);
        logic [7:0] b;
        begin
            unique case (pos)
                3'd0:    b = 8'hE1;
                3'd1:    b = 8'h1D;
                3'd2:    b = 8'h45;
                3'd3:    b = 8'hE1;
                3'd4:    b = 8'h9D;
                3'd5:    b = 8'hC5;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/sks1_key_table.sv
`timescale 1ns / 1ps
`default_nettype none

module sks1_key_table #(
    parameter int COLS = 2,
    parameter int KW   = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                wr_en,
    input  wire logic [7:0]                          wr_index,
    input  wire logic [15:0]                         wr_value,
    input  wire logic                                rd_en,
    input  wire logic [sks1_pkg::ROW_BITS-1:0]       rd_row,
    output logic      [COLS-1:0][KW-1:0]             rd_data
);

    localparam int COL_BITS   = $clog2(COLS);
    localparam int TABLE_SIZE = sks1_pkg::TABLE_ROWS * COLS;
    localparam int DIV_SHIFT  = 12;
    localparam int RECIP      = ((1 << DIV_SHIFT) + COLS - 1) / COLS;

    logic [COLS-1:0][KW-1:0] mem [sks1_pkg::TABLE_ROWS];
    logic [sks1_pkg::TABLE_ROWS-1:0] valid_reg;
    logic [COLS-1:0][KW-1:0] rd_data_reg;
    logic [COLS-1:0][KW-1:0] fresh_row;

    logic [19:0]                   prod;
    logic [7:0]                    row_full;
    logic [9:0]                    row_base;
    logic [9:0]                    col_full;
    logic [sks1_pkg::ROW_BITS-1:0] wr_row;
    logic [COL_BITS-1:0]           wr_col;
    logic                          wr_ok;
    logic [31:0]                   wr_wide;

    // Split the flat index into row and column by reciprocal multiply
    assign prod     = 20'(wr_index) * 20'(RECIP);
    assign row_full = prod[DIV_SHIFT+7:DIV_SHIFT];
    assign row_base = 10'(row_full) * 10'(COLS);
    assign col_full = 10'(wr_index) - row_base;
    assign wr_row   = row_full[sks1_pkg::ROW_BITS-1:0];
    assign wr_col   = col_full[COL_BITS-1:0];
    assign wr_ok    = wr_en && (int'(wr_index) < TABLE_SIZE);
    assign wr_wide  = 32'(wr_value);

    // First write to a row fills its other columns with zeros
    always_comb
    begin
        fresh_row         = '0;
        fresh_row[wr_col] = wr_wide[KW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            if (valid_reg[wr_row])
            begin
                mem[wr_row][wr_col] <= wr_wide[KW-1:0];
            end
            else
            begin
                mem[wr_row] <= fresh_row;
            end
        end
    end

    // One valid bit per row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_ok)
        begin
            valid_reg[wr_row] <= 1'b1;
        end
    end

    // Read a whole row; forward a write landing on the same entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                if (wr_ok && wr_row == rd_row && wr_col == COL_BITS'(c))
                begin
                    rd_data_reg[c] <= wr_wide[KW-1:0];
                end
                else if (valid_reg[rd_row])
                begin
                    rd_data_reg[c] <= mem[rd_row][c];
                end
                else
                begin
                    rd_data_reg[c] <= '0;
                end
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/sks1_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module sks1_decode #(
    parameter int COLS = 2,
    parameter int KW   = 16
) (
    input  wire logic [7:0]                  scan_byte,
    input  wire sks1_pkg::dec_state_t        cur,
    input  wire logic [COLS-1:0][KW-1:0]     row_data,
    input  wire logic [15:0]                 pause_code,
    input  wire logic [15:0]                 print_screen_code,
    input  wire logic [15:0]                 other_prefixed_code,
    output sks1_pkg::dec_state_t             nxt,
    output sks1_pkg::key_result_t            res
);

    localparam int COL_BITS = $clog2(COLS);

    logic        make;
    logic [6:0]  row;
    logic        shift_now;
    logic [KW-1:0] key_sel;
    logic [31:0] key_wide;
    logic        emit_req;
    logic [15:0] emit_code;
    logic        emit_make;

    assign make      = !scan_byte[7];
    assign row       = scan_byte[6:0];
    assign shift_now = cur.mods[sks1_pkg::MOD_SHIFT_L] | cur.mods[sks1_pkg::MOD_SHIFT_R];
    assign key_sel   = row_data[COL_BITS'(shift_now)];
    assign key_wide  = 32'(key_sel);

    always_comb
    begin
        nxt       = cur;
        emit_req  = 1'b0;
        emit_code = '0;
        emit_make = 1'b1;
        unique case (cur.phase) inside
            sks1_pkg::PH_E0:
            begin
                nxt.phase = sks1_pkg::PH_IDLE;
                unique case (scan_byte)
                    sks1_pkg::SC_PS_MAKE:    nxt.phase = sks1_pkg::PH_PS_MAKE_E0;
                    sks1_pkg::SC_PS_BREAK:   nxt.phase = sks1_pkg::PH_PS_BRK_E0;
                    sks1_pkg::SC_CTRL_MAKE:  nxt.mods[sks1_pkg::MOD_CTRL_R] = 1'b1;
                    sks1_pkg::SC_CTRL_BREAK: nxt.mods[sks1_pkg::MOD_CTRL_R] = 1'b0;
                    sks1_pkg::SC_ALT_MAKE:   nxt.mods[sks1_pkg::MOD_ALT_R]  = 1'b1;
                    sks1_pkg::SC_ALT_BREAK:  nxt.mods[sks1_pkg::MOD_ALT_R]  = 1'b0;
                    default:
                    begin
                        emit_req  = make;
                        emit_code = other_prefixed_code;
                    end
                endcase
            end
            sks1_pkg::PH_PS_MAKE_E0, sks1_pkg::PH_PS_MAKE_37:
            begin
                if (cur.phase == sks1_pkg::PH_PS_MAKE_E0 && scan_byte == sks1_pkg::SC_PREFIX_E0)
                begin
                    nxt.phase = sks1_pkg::PH_PS_MAKE_37;
                end
                else if (cur.phase == sks1_pkg::PH_PS_MAKE_37
                         && scan_byte == sks1_pkg::SC_PS_KEY)
                begin
                    nxt.phase = sks1_pkg::PH_IDLE;
                    emit_req  = 1'b1;
                    emit_code = print_screen_code;
                end
                else
                begin
                    // Broken sequence: the fake shift press stands
                    nxt.phase = sks1_pkg::PH_IDLE;
                    nxt.mods[sks1_pkg::MOD_SHIFT_L] = 1'b1;
                end
            end
            sks1_pkg::PH_PS_BRK_E0:
            begin
                nxt.phase = (scan_byte == sks1_pkg::SC_PREFIX_E0) ? sks1_pkg::PH_PS_BRK_AA
                                                                  : sks1_pkg::PH_IDLE;
            end
            sks1_pkg::PH_PS_BRK_AA:
            begin
                nxt.phase = sks1_pkg::PH_IDLE;
                if (scan_byte == sks1_pkg::SC_PS_RELEASE)
                begin
                    emit_req  = 1'b1;
                    emit_code = print_screen_code;
                    emit_make = 1'b0;
                end
            end
            sks1_pkg::PH_PAUSE:
            begin
                if (cur.pause_cnt != 3'd0 && cur.pause_cnt < sks1_pkg::PAUSE_LEN
                    && scan_byte == sks1_pkg::pause_byte(cur.pause_cnt))
                begin
                    if (cur.pause_cnt == sks1_pkg::PAUSE_LEN - 3'd1)
                    begin
                        nxt.pause_cnt = '0;
                        nxt.phase     = sks1_pkg::PH_IDLE;
                        emit_req      = 1'b1;
                        emit_code     = pause_code;
                    end
                    else
                    begin
                        nxt.pause_cnt = cur.pause_cnt + 3'd1;
                    end
                end
                else
                begin
                    nxt.pause_cnt = '0;
                    nxt.phase     = sks1_pkg::PH_IDLE;
                end
            end
            default:
            begin
                nxt.phase     = sks1_pkg::PH_IDLE;
                nxt.pause_cnt = '0;
                if (scan_byte == sks1_pkg::SC_PREFIX_E1)
                begin
                    nxt.phase     = sks1_pkg::PH_PAUSE;
                    nxt.pause_cnt = 3'd1;
                end
                else if (scan_byte == sks1_pkg::SC_PREFIX_E0)
                begin
                    nxt.phase = sks1_pkg::PH_E0;
                end
                else
                begin
                    unique case (row)
                        sks1_pkg::ROW_SHIFT_L: nxt.mods[sks1_pkg::MOD_SHIFT_L] = make;
                        sks1_pkg::ROW_SHIFT_R: nxt.mods[sks1_pkg::MOD_SHIFT_R] = make;
                        sks1_pkg::ROW_CTRL_L:  nxt.mods[sks1_pkg::MOD_CTRL_L]  = make;
                        sks1_pkg::ROW_ALT_L:   nxt.mods[sks1_pkg::MOD_ALT_L]   = make;
                        sks1_pkg::ROW_ESCAPE:  ;
                        default:
                        begin
                            emit_req  = make;
                            emit_code = key_wide[15:0];
                        end
                    endcase
                end
            end
        endcase
    end

    // Flags reflect the modifiers after this byte
    always_comb
    begin
        res.valid      = emit_req && (emit_code != 16'd0);
        res.key_code   = emit_code;
        res.is_make    = emit_make;
        res.shift_held = nxt.mods[sks1_pkg::MOD_SHIFT_L] | nxt.mods[sks1_pkg::MOD_SHIFT_R];
        res.ctrl_held  = nxt.mods[sks1_pkg::MOD_CTRL_L]  | nxt.mods[sks1_pkg::MOD_CTRL_R];
        res.alt_held   = nxt.mods[sks1_pkg::MOD_ALT_L]   | nxt.mods[sks1_pkg::MOD_ALT_R];
    end

endmodule

`default_nettype wire

// File: sv/scancode_set1_key_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Ports                          Contents
// s_*       in   s_tvalid s_tready s_tdata      scan byte or key table write word
//                s_tuser                        word kind (scan / table write)
// m_*       out  m_tvalid m_tready m_tdata      decoded key with modifier state
//                m_tuser                        make / break
// cfg_*     in   cfg_we cfg_index cfg_data      pause, print screen, other E0 codes
//
// One word is taken every clock while s_tready is high. A word is held in the
// input register, decoded against the prefix state and the key table row read at
// its acceptance, and its result goes to the output register as the decode stage
// advances. Only a scan word with a nonzero code raises m_tvalid. The key table
// row read is done at acceptance so the decode stage holds only a column select.
// Reset clears the prefix state, modifiers, the output stage and the table row
// valid bits at once; no clearing pass is run. A stalled result holds the
// output register, and the input register fills behind it before s_tready drops.

module scancode_set1_key_decoder #(
    parameter int TABLE_COLUMNS = 2,
    parameter int KEY_WIDTH     = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // scan_byte [7:0], table_index [15:8], table_value [31:16]
    input  wire logic [31:0] s_tdata,
    // opcode [0]
    input  wire logic [0:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // key_code [15:0], shift_held [16], ctrl_held [17], alt_held [18], zero [23:19]
    output logic [23:0]      m_tdata,
    // is_make [0]
    output logic [0:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;
    logic [7:0]  in_index_reg;
    logic [15:0] in_value_reg;

    // Decoder state
    sks1_pkg::dec_state_t state_reg, state_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    sks1_pkg::key_result_t out_reg;

    // Configuration
    logic [15:0] pause_code_reg;
    logic [15:0] print_screen_code_reg;
    logic [15:0] other_prefixed_code_reg;

    logic accept_in;
    logic advance;
    logic step;
    logic step_scan;

    logic [TABLE_COLUMNS-1:0][KEY_WIDTH-1:0] row_data;
    sks1_pkg::dec_state_t  dec_next;
    sks1_pkg::key_result_t dec_res;

    // Advance the decode stage whenever the output register is free or drains
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign accept_in = s_tvalid && s_tready;
    assign step      = in_valid_reg && advance;
    assign step_scan = step && (in_op_reg == sks1_pkg::OP_SCAN);

    sks1_key_table #(
        .COLS (TABLE_COLUMNS),
        .KW   (KEY_WIDTH)
    ) u_key_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (step && (in_op_reg == sks1_pkg::OP_TABLE_WRITE)),
        .wr_index (in_index_reg),
        .wr_value (in_value_reg),
        .rd_en    (accept_in),
        .rd_row   (s_tdata[sks1_pkg::ROW_BITS-1:0]),
        .rd_data  (row_data)
    );

    sks1_decode #(
        .COLS (TABLE_COLUMNS),
        .KW   (KEY_WIDTH)
    ) u_decode (
        .scan_byte           (in_byte_reg),
        .cur                 (state_reg),
        .row_data            (row_data),
        .pause_code          (pause_code_reg),
        .print_screen_code   (print_screen_code_reg),
        .other_prefixed_code (other_prefixed_code_reg),
        .nxt                 (dec_next),
        .res                 (dec_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Table writes leave the prefix state alone
    assign state_next     = step_scan ? dec_next : state_reg;
    assign out_valid_next = advance ? (step_scan && dec_res.valid) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload: load the input word on acceptance
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_op_reg    <= s_tuser[0];
            in_byte_reg  <= s_tdata[7:0];
            in_index_reg <= s_tdata[15:8];
            in_value_reg <= s_tdata[31:16];
        end
    end

    // Payload: hold the result while the sink stalls
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= dec_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pause_code_reg          <= '0;
            print_screen_code_reg   <= '0;
            other_prefixed_code_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sks1_pkg::REG_PAUSE_CODE:   pause_code_reg          <= cfg_data;
                sks1_pkg::REG_PRINT_SCREEN: print_screen_code_reg   <= cfg_data;
                sks1_pkg::REG_OTHER_PREFIX: other_prefixed_code_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.alt_held, out_reg.ctrl_held, out_reg.shift_held,
                       out_reg.key_code};
    assign m_tuser  = out_reg.is_make;

endmodule

`default_nettype wire

// File: sv/sks1_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sks1_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    // Hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // Zero codes are dropped, never delivered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:0] != 16'd0)
        else $error("result word with zero key code");

    // An empty output stage never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // A fresh result rises once its word has passed the input register into the
    // output register, so the check looks back to the edge that accepted the word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result word without a matching input word");

endmodule

bind scancode_set1_key_decoder sks1_checker u_sks1_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
